>>> design/lto_pkg.sv
// Shared types and constants for the line track offset filter.
// No dependencies; every other design file refers to this package by scoped names.
package lto_pkg;

    localparam int TRACK_W     = 16;
    localparam int POS_N       = 15;
    localparam int SUM3_W      = 2;
    localparam int POS_W       = 4;
    localparam int RAW_ERR_W   = 5;
    localparam int WHITE_W     = 4;
    localparam int OFFSET_W    = 7;
    localparam int QUEUE_DEPTH = 2;

    // Window search covers positions 1..13, centre of the line is 7 (14 in halves)
    localparam logic [POS_W-1:0]     WIN_FIRST  = 4'd1;
    localparam logic [POS_W-1:0]     WIN_LAST   = 4'd13;
    localparam logic [RAW_ERR_W-1:0] CENTER_X2  = 5'd14;

    // Saturation limits of the offset output
    localparam int OFFSET_MAX = 63;
    localparam int OFFSET_MIN = -64;

    typedef struct packed {
        logic signed [RAW_ERR_W-1:0] raw_error_halves;
        logic [WHITE_W-1:0]          white_count;
    } class_t;

endpackage

>>> design/lto_front.sv
// Front end: interleaves a track word, counts whites, finds the darkest window.
// Depends on lto_pkg; feeds lto_queue.
module lto_front (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lto_pkg::TRACK_W-1:0] s_track_bits,
    output logic                        push,
    output lto_pkg::class_t             push_data,
    input  logic                        q_full
);

    logic [lto_pkg::POS_N-1:0]  line;
    logic [lto_pkg::SUM3_W-1:0] sums [1:13];
    logic [13:1]                is_min;
    logic [13:1]                eq0, eq1, eq2;
    logic [lto_pkg::SUM3_W-1:0] minimum;
    logic [lto_pkg::POS_W-1:0]  first_pos, last_pos;
    logic [lto_pkg::RAW_ERR_W-1:0] fl_sum;
    logic [lto_pkg::WHITE_W-1:0] whites;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    // Interleave rear and front bits; bit 7 is unused
    always_comb begin
        for (int i = 0; i < 7; i++) begin
            line[2*i]   = s_track_bits[8+i];
            line[2*i+1] = s_track_bits[i];
        end
        line[14] = s_track_bits[15];
    end

    always_comb begin
        whites = '0;
        for (int p = 0; p < lto_pkg::POS_N; p++) begin
            whites = whites + lto_pkg::WHITE_W'(line[p]);
        end
    end

    // Window sums and their minimum, found by flags rather than a chain
    always_comb begin
        for (int p = 1; p < 14; p++) begin
            sums[p] = lto_pkg::SUM3_W'(line[p-1]) + lto_pkg::SUM3_W'(line[p])
                    + lto_pkg::SUM3_W'(line[p+1]);
            eq0[p]  = (sums[p] == 2'd0);
            eq1[p]  = (sums[p] == 2'd1);
            eq2[p]  = (sums[p] == 2'd2);
        end
        if (|eq0) begin
            minimum = 2'd0;
        end else if (|eq1) begin
            minimum = 2'd1;
        end else if (|eq2) begin
            minimum = 2'd2;
        end else begin
            minimum = 2'd3;
        end
        for (int p = 1; p < 14; p++) begin
            is_min[p] = (sums[p] == minimum);
        end
    end

    // First and last window holding the minimum
    always_comb begin
        first_pos = lto_pkg::WIN_LAST;
        last_pos  = lto_pkg::WIN_FIRST;
        for (int p = 13; p >= 1; p--) begin
            if (is_min[p]) begin
                first_pos = lto_pkg::POS_W'(p);
            end
        end
        for (int p = 1; p < 14; p++) begin
            if (is_min[p]) begin
                last_pos = lto_pkg::POS_W'(p);
            end
        end
    end

    assign fl_sum = lto_pkg::RAW_ERR_W'(first_pos) + lto_pkg::RAW_ERR_W'(last_pos);

    always_comb begin
        push_data.raw_error_halves = signed'(lto_pkg::CENTER_X2 - fl_sum);
        push_data.white_count      = whites;
    end

endmodule

>>> design/lto_queue.sv
// Two-word queue between the front end and the filter back end.
// Depends on lto_pkg for the word type and depth.
module lto_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lto_pkg::class_t push_data,
    output logic            q_full,
    output logic            q_valid,
    input  logic            pop,
    output lto_pkg::class_t pop_data
);

    localparam int QPTR_W = $clog2(lto_pkg::QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(lto_pkg::QUEUE_DEPTH + 1);

    lto_pkg::class_t    mem_reg [lto_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign q_full   = (count_reg == QCNT_W'(lto_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(lto_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(lto_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(lto_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

>>> design/lto_back.sv
// Back end: error history ring, windowed sum with saturation, result register.
// Depends on lto_pkg; drains lto_queue.
module lto_back #(
    parameter int FILTER_DEPTH = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    output logic                                 pop,
    input  lto_pkg::class_t                      pop_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lto_pkg::OFFSET_W-1:0]  m_offset_sixths,
    output logic [lto_pkg::WHITE_W-1:0]          m_white_count,
    output logic signed [lto_pkg::RAW_ERR_W-1:0] m_raw_error_halves
);

    localparam int PTR_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int SUM_W = lto_pkg::RAW_ERR_W + $clog2(FILTER_DEPTH) + 3;

    logic signed [lto_pkg::RAW_ERR_W-1:0] history_reg [FILTER_DEPTH];
    logic [PTR_W-1:0]                     ptr_reg, ptr_next;
    logic                                 m_valid_reg, m_valid_next;
    logic signed [lto_pkg::OFFSET_W-1:0]  offset_reg, offset_next;
    logic [lto_pkg::WHITE_W-1:0]          white_reg;
    logic signed [lto_pkg::RAW_ERR_W-1:0] raw_reg;
    logic signed [SUM_W-1:0]              total;

    // Advance when the result slot is free or being taken
    assign pop = q_valid && (!m_valid_reg || m_ready);

    assign m_valid            = m_valid_reg;
    assign m_offset_sixths    = offset_reg;
    assign m_white_count      = white_reg;
    assign m_raw_error_halves = raw_reg;

    assign ptr_next = (ptr_reg == PTR_W'(FILTER_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    // Sum of the ring as it will stand after this word's error is written
    always_comb begin
        total = '0;
        for (int k = 0; k < FILTER_DEPTH; k++) begin
            if (PTR_W'(k) == ptr_reg) begin
                total = total + SUM_W'(pop_data.raw_error_halves);
            end else begin
                total = total + SUM_W'(history_reg[k]);
            end
        end
        if (total > SUM_W'(lto_pkg::OFFSET_MAX)) begin
            offset_next = lto_pkg::OFFSET_W'(lto_pkg::OFFSET_MAX);
        end else if (total < SUM_W'(lto_pkg::OFFSET_MIN)) begin
            offset_next = lto_pkg::OFFSET_W'(lto_pkg::OFFSET_MIN);
        end else begin
            offset_next = total[lto_pkg::OFFSET_W-1:0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < FILTER_DEPTH; k++) begin
                history_reg[k] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                ptr_reg              <= ptr_next;
                history_reg[ptr_reg] <= pop_data.raw_error_halves;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            offset_reg <= offset_next;
            white_reg  <= pop_data.white_count;
            raw_reg    <= pop_data.raw_error_halves;
        end
    end

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= PTR_W'(FILTER_DEPTH - 1))
        else $error("history pointer out of range");

    a_pop_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_valid_reg)
        else $error("popped word not presented");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(offset_reg)
                                       && $stable(white_reg) && $stable(raw_reg)))
        else $error("stalled result word changed");

endmodule

>>> design/line_track_offset_filter.sv
// Top level of the line track offset filter.
// Depends on lto_pkg, lto_front, lto_queue and lto_back.
//
// One 16-bit sensor word in, one result word out, one per clock if m_ready is high.
// The front end interleaves rear bits 8..15 and front bits 0..6 into 15 positions
// (bit 7 is dropped), counts white bits, and locates the first and last three-wide
// window with the smallest sum; the raw error is 14 - first - last in half positions.
// Classified words go into a two-word queue. The back end writes each raw error
// into a FILTER_DEPTH-entry ring (cleared at reset, so the output ramps up over the
// first FILTER_DEPTH words) and registers the ring sum, saturated to -64..63; at a
// depth of three this is the offset in sixths of a position. An accepted word is
// written first into the queue and then into the result register, which drives
// m_valid. The queue and result register together absorb three words of output
// stall before s_ready drops. No clearing pass: the block accepts words right
// after reset.
module line_track_offset_filter #(
    parameter int FILTER_DEPTH = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lto_pkg::TRACK_W-1:0]          s_track_bits,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lto_pkg::OFFSET_W-1:0]  m_offset_sixths,
    output logic [lto_pkg::WHITE_W-1:0]          m_white_count,
    output logic signed [lto_pkg::RAW_ERR_W-1:0] m_raw_error_halves
);

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_valid;
    lto_pkg::class_t push_data;
    lto_pkg::class_t pop_data;

    // Classify the incoming word; hold s_ready low while the queue is full
    lto_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_track_bits (s_track_bits),
        .push         (push),
        .push_data    (push_data),
        .q_full       (q_full)
    );

    // Decouple classification from filtering
    lto_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    // Update the ring and present the filtered word
    lto_back #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .pop                (pop),
        .pop_data           (pop_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_offset_sixths    (m_offset_sixths),
        .m_white_count      (m_white_count),
        .m_raw_error_halves (m_raw_error_halves)
    );

endmodule
